// File: rtl/afs_pkg.sv
// ----------------------------------------------------------------------------
// afs_pkg
// shared types and constants for the animation frame sequencer
// ----------------------------------------------------------------------------
package afs_pkg;

    localparam int MAX_FRAMES = 256;
    localparam int FRAME_AW   = $clog2(MAX_FRAMES);

    localparam logic [29:0] NS_PER_SEC   = 30'd1000000000;
    localparam logic [63:0] MIN_DUR_NS   = 64'd10000000;
    localparam logic [15:0] DEFAULT_DEN  = 16'd100;

    localparam int PROD_W = 46;   // 16-bit numerator times 30-bit constant
    localparam int DIVD_W = 47;   // product plus rounding term
    localparam int NUM_W  = 16;

    // request codes
    localparam logic [2:0] REQ_LOAD  = 3'd0;
    localparam logic [2:0] REQ_PLAY  = 3'd1;
    localparam logic [2:0] REQ_PAUSE = 3'd2;
    localparam logic [2:0] REQ_SEEK  = 3'd3;
    localparam logic [2:0] REQ_TICK  = 3'd4;
    localparam logic [2:0] REQ_READY = 3'd5;

    // speed codes
    localparam logic [1:0] SPD_QUARTER = 2'd0;
    localparam logic [1:0] SPD_HALF    = 2'd1;
    localparam logic [1:0] SPD_NORMAL  = 2'd2;
    localparam logic [1:0] SPD_DOUBLE  = 2'd3;

    // register indexes
    localparam logic [1:0] REG_FRAME_COUNT = 2'd0;
    localparam logic [1:0] REG_PLAY_COUNT  = 2'd1;
    localparam logic [1:0] REG_SPEED_MODE  = 2'd2;

    typedef enum logic [2:0] {
        MODE_PAUSED  = 3'd0,
        MODE_PLAYING = 3'd1,
        MODE_WAITING = 3'd2,
        MODE_ENDED   = 3'd3,
        MODE_ERROR   = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_MUL,
        ST_DIVINIT,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } t_state;

endpackage

// File: rtl/animation_frame_sequencer.sv
// ----------------------------------------------------------------------------
// animation_frame_sequencer
// event-driven frame playback timing with a per-frame delay table
// ----------------------------------------------------------------------------
// most events pass from accept through the exec and done steps to the result beat
// a tick that must check the frame delay also passes a table read, a 16-step
//   bit-serial multiply, a 47-step bit-serial restoring divide and a final step
// one event is in flight at a time; a stalled result beat holds off the next event
// synchronous active-low reset clears control and playback state; the delay
//   table is not cleared and holds garbage until each entry is loaded
module animation_frame_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [63:0] i_now_ns,
    input  logic [7:0]  i_frame_index,
    input  logic [15:0] i_delay_num,
    input  logic [15:0] i_delay_den,
    input  logic [63:0] i_ready_serial,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_show_valid,
    output logic [7:0]  o_show_index,
    output logic [63:0] o_show_serial,
    output logic        o_seek_ok,
    output logic [2:0]  o_play_state,
    output logic [31:0] o_plays_done,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [8:0]  r_frame_count;
    logic [31:0] r_play_count;
    logic [1:0]  r_speed;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
            r_play_count  <= '0;
            r_speed       <= afs_pkg::SPD_NORMAL;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                afs_pkg::REG_FRAME_COUNT: r_frame_count <= pwdata[8:0];
                afs_pkg::REG_PLAY_COUNT:  r_play_count  <= pwdata;
                afs_pkg::REG_SPEED_MODE:  r_speed       <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            afs_pkg::REG_FRAME_COUNT: prdata = {23'd0, r_frame_count};
            afs_pkg::REG_PLAY_COUNT:  prdata = r_play_count;
            afs_pkg::REG_SPEED_MODE:  prdata = {30'd0, r_speed};
            default:                  prdata = '0;
        endcase
    end

    // active frame count, capped at the table depth
    logic [8:0] count;
    assign count = (r_frame_count > 9'(afs_pkg::MAX_FRAMES)) ?
                   9'(afs_pkg::MAX_FRAMES) : r_frame_count;

    // ------------------------------------------------------------------
    // captured event beat
    // ------------------------------------------------------------------
    logic [2:0]  r_req;
    logic [63:0] r_now;
    logic [7:0]  r_idx;
    logic [15:0] r_num_in;
    logic [15:0] r_den_in;
    logic [63:0] r_rser;

    logic accept;
    assign accept = i_valid & o_ready;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req    <= i_req_type;
            r_now    <= i_now_ns;
            r_idx    <= i_frame_index;
            r_num_in <= i_delay_num;
            r_den_in <= i_delay_den;
            r_rser   <= i_ready_serial;
        end
    end

    // ------------------------------------------------------------------
    // sequencer state
    // ------------------------------------------------------------------
    afs_pkg::t_state r_state, n_state;
    logic [5:0]      r_cnt, n_cnt;

    // playback state
    logic [7:0]      r_cur, n_cur;
    logic [31:0]     r_loops, n_loops;
    logic [63:0]     r_serial, n_serial;
    logic            r_shown, n_shown;
    logic [63:0]     r_start, n_start;
    afs_pkg::t_mode  r_mode, n_mode;
    logic            r_res_show, n_res_show;
    logic            r_res_seek, n_res_seek;

    // arithmetic datapath
    logic [31:0]                  r_rd_data;   // num in high half shifts out msb first
    logic [afs_pkg::PROD_W-1:0]   r_acc;
    logic [afs_pkg::DIVD_W-1:0]   r_quo;       // dividend shifts out, quotient shifts in
    logic [15:0]                  r_rem;
    logic [15:0]                  den_eff;

    assign o_ready = (r_state == afs_pkg::ST_IDLE);
    assign den_eff = (r_rd_data[15:0] == 16'd0) ? afs_pkg::DEFAULT_DEN : r_rd_data[15:0];

    // delay table, written at the event index on load, read for the current frame
    logic [31:0] mem [afs_pkg::MAX_FRAMES];
    logic        mem_we;
    assign mem_we = (r_state == afs_pkg::ST_EXEC) && (r_req == afs_pkg::REQ_LOAD);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_idx[afs_pkg::FRAME_AW-1:0]] <= {r_num_in, r_den_in};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == afs_pkg::ST_READ) begin
            r_rd_data <= mem[r_cur[afs_pkg::FRAME_AW-1:0]];
        end else if (r_state == afs_pkg::ST_MUL) begin
            r_rd_data <= {r_rd_data[30:16], 1'b0, r_rd_data[15:0]};
        end
    end

    // bit-serial multiply: acc = acc*2 + (num bit ? 1e9 : 0)
    // bit-serial restoring divide of (product + den - 1) by den
    logic [16:0] div_trial;
    logic        div_bit;
    assign div_trial = {r_rem, r_quo[afs_pkg::DIVD_W-1]};
    assign div_bit   = (div_trial >= {1'b0, den_eff});

    always_ff @(posedge i_clk) begin
        case (r_state)
            afs_pkg::ST_READ: begin
                r_acc <= '0;
            end
            afs_pkg::ST_MUL: begin
                r_acc <= {r_acc[afs_pkg::PROD_W-2:0], 1'b0} +
                         (r_rd_data[31] ? afs_pkg::PROD_W'(afs_pkg::NS_PER_SEC)
                                        : afs_pkg::PROD_W'(0));
            end
            afs_pkg::ST_DIVINIT: begin
                r_quo <= afs_pkg::DIVD_W'(r_acc) + afs_pkg::DIVD_W'(den_eff)
                         - afs_pkg::DIVD_W'(1);
                r_rem <= '0;
            end
            afs_pkg::ST_DIV: begin
                r_quo <= {r_quo[afs_pkg::DIVD_W-2:0], div_bit};
                r_rem <= div_bit ? 16'(div_trial - {1'b0, den_eff}) : div_trial[15:0];
            end
            default: ;
        endcase
    end

    // speed scaling and the 10 ms floor
    logic [48:0] scaled;
    logic [63:0] dur;
    logic [63:0] elapsed;
    logic        expired;

    always_comb begin
        case (r_speed)
            afs_pkg::SPD_QUARTER: scaled = {r_quo, 2'b00};
            afs_pkg::SPD_HALF:    scaled = {1'b0, r_quo, 1'b0};
            afs_pkg::SPD_NORMAL:  scaled = {2'b00, r_quo};
            default:              scaled = 49'((({2'b00, r_quo}) + 49'd1) >> 1);
        endcase
    end

    assign dur     = ({15'd0, scaled} < afs_pkg::MIN_DUR_NS) ? afs_pkg::MIN_DUR_NS
                                                              : {15'd0, scaled};
    assign elapsed = r_now - r_start;
    assign expired = (elapsed >= dur);

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    logic tick_needs_time;
    assign tick_needs_time = (r_mode == afs_pkg::MODE_PLAYING) && (count != 9'd0) &&
                             r_shown && (r_now >= r_start);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            afs_pkg::ST_IDLE: begin
                if (accept) n_state = afs_pkg::ST_EXEC;
            end
            afs_pkg::ST_EXEC: begin
                if (r_req == afs_pkg::REQ_TICK && tick_needs_time) begin
                    n_state = afs_pkg::ST_READ;
                end else begin
                    n_state = afs_pkg::ST_DONE;
                end
            end
            afs_pkg::ST_READ: begin
                n_state = afs_pkg::ST_MUL;
                n_cnt   = '0;
            end
            afs_pkg::ST_MUL: begin
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(afs_pkg::NUM_W - 1)) n_state = afs_pkg::ST_DIVINIT;
            end
            afs_pkg::ST_DIVINIT: begin
                n_state = afs_pkg::ST_DIV;
                n_cnt   = '0;
            end
            afs_pkg::ST_DIV: begin
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(afs_pkg::DIVD_W - 1)) n_state = afs_pkg::ST_FIN;
            end
            afs_pkg::ST_FIN: begin
                n_state = afs_pkg::ST_DONE;
            end
            afs_pkg::ST_DONE: begin
                if (!o_valid || i_ready) n_state = afs_pkg::ST_IDLE;
            end
            default: n_state = afs_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // playback updates, done in the exec step or after the delay check
    // ------------------------------------------------------------------
    logic [8:0]  cur_next;
    logic [32:0] loops_next;

    assign cur_next   = {1'b0, r_cur} + 9'd1;
    assign loops_next = {1'b0, r_loops} + 33'd1;

    always_comb begin
        n_cur      = r_cur;
        n_loops    = r_loops;
        n_serial   = r_serial;
        n_shown    = r_shown;
        n_start    = r_start;
        n_mode     = r_mode;
        n_res_show = r_res_show;
        n_res_seek = r_res_seek;
        case (r_state)
            afs_pkg::ST_EXEC: begin
                n_res_show = 1'b0;
                n_res_seek = 1'b0;
                case (r_req)
                    afs_pkg::REQ_PLAY: begin
                        if (count == 9'd0) begin
                            n_mode = afs_pkg::MODE_ERROR;
                        end else if (r_mode == afs_pkg::MODE_PAUSED ||
                                     r_mode == afs_pkg::MODE_ENDED) begin
                            if (r_mode == afs_pkg::MODE_ENDED) begin
                                n_cur    = '0;
                                n_loops  = '0;
                                n_serial = '0;
                                n_shown  = 1'b0;
                            end
                            n_start = r_now;
                            n_mode  = afs_pkg::MODE_PLAYING;
                        end
                    end
                    afs_pkg::REQ_PAUSE: begin
                        if (r_mode == afs_pkg::MODE_PLAYING ||
                            r_mode == afs_pkg::MODE_WAITING) begin
                            n_mode  = afs_pkg::MODE_PAUSED;
                            n_shown = 1'b0;
                        end
                    end
                    afs_pkg::REQ_SEEK: begin
                        if (r_mode == afs_pkg::MODE_PAUSED && {1'b0, r_idx} < count) begin
                            n_cur      = r_idx;
                            n_start    = r_now;
                            n_shown    = 1'b0;
                            n_serial   = '0;
                            n_res_seek = 1'b1;
                        end
                    end
                    afs_pkg::REQ_TICK: begin
                        // first tick of a frame just requests it
                        if (r_mode == afs_pkg::MODE_PLAYING && count != 9'd0 && !r_shown) begin
                            n_serial   = r_serial + 64'd1;
                            n_mode     = afs_pkg::MODE_WAITING;
                            n_res_show = 1'b1;
                        end
                    end
                    afs_pkg::REQ_READY: begin
                        if (r_mode == afs_pkg::MODE_WAITING && r_idx == r_cur &&
                            r_rser == r_serial) begin
                            n_shown = 1'b1;
                            n_start = r_now;
                            n_mode  = afs_pkg::MODE_PLAYING;
                        end
                    end
                    default: ;
                endcase
            end
            afs_pkg::ST_FIN: begin
                if (expired) begin
                    if (cur_next < count) begin
                        n_cur      = cur_next[7:0];
                        n_shown    = 1'b0;
                        n_serial   = r_serial + 64'd1;
                        n_mode     = afs_pkg::MODE_WAITING;
                        n_res_show = 1'b1;
                    end else if (r_play_count == 32'd0 ||
                                 loops_next < {1'b0, r_play_count}) begin
                        // wrap to a new loop, count saturates
                        if (r_loops != 32'hFFFF_FFFF) n_loops = loops_next[31:0];
                        n_cur      = '0;
                        n_shown    = 1'b0;
                        n_serial   = r_serial + 64'd1;
                        n_mode     = afs_pkg::MODE_WAITING;
                        n_res_show = 1'b1;
                    end else begin
                        n_mode = afs_pkg::MODE_ENDED;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= afs_pkg::ST_IDLE;
            r_cnt      <= '0;
            r_cur      <= '0;
            r_loops    <= '0;
            r_serial   <= '0;
            r_shown    <= 1'b0;
            r_start    <= '0;
            r_mode     <= afs_pkg::MODE_PAUSED;
            r_res_show <= 1'b0;
            r_res_seek <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_cur      <= n_cur;
            r_loops    <= n_loops;
            r_serial   <= n_serial;
            r_shown    <= n_shown;
            r_start    <= n_start;
            r_mode     <= n_mode;
            r_res_show <= n_res_show;
            r_res_seek <= n_res_seek;
        end
    end

    // ------------------------------------------------------------------
    // result register, loaded from the done step when the slot is free
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic out_load;
    assign out_load = (r_state == afs_pkg::ST_DONE) && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_show_valid  <= r_res_show;
            o_show_index  <= r_res_show ? r_cur : 8'd0;
            o_show_serial <= r_res_show ? r_serial : 64'd0;
            o_seek_ok     <= r_res_seek;
            o_play_state  <= r_mode;
            o_plays_done  <= r_loops;
        end
    end

`ifndef ASSERT_OFF
    // a fetch request always leaves the player waiting for the frame
    a_show_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_show_valid) |-> (o_play_state == afs_pkg::MODE_WAITING))
        else $error("fetch beat without waiting state");

    // an accepted seek only happens while paused
    a_seek_paused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_seek_ok) |-> (o_play_state == afs_pkg::MODE_PAUSED))
        else $error("seek beat outside paused state");

    // multiply phase never runs past the numerator width
    a_mul_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == afs_pkg::ST_MUL) |-> (r_cnt < 6'(afs_pkg::NUM_W)))
        else $error("multiply counter overrun");
`endif

endmodule
